### rtl/core/assert_macros.svh
// Assertion shorthands shared by the checker files.
// Both sample on posedge clk and are disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CHK_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/core/rtcbe_pkg.sv
// Types, constants and small functions for the BCD RTC / epoch converter.
// No dependencies; used by the converter and its checker.
package rtcbe_pkg;

  typedef enum logic {
    OP_DECODE = 1'b0,
    OP_ENCODE = 1'b1
  } op_t;

  localparam int unsigned NUM_STG = 6;

  // Register masks and BCD nibble mask
  localparam logic [7:0] MASK_MS  = 8'h7F;
  localparam logic [7:0] MASK_HD  = 8'h3F;
  localparam logic [7:0] MASK_MON = 8'h1F;
  localparam logic [3:0] MASK_NIB = 4'hF;

  // Year register holds year - 1970; valid window 2020..2069
  localparam int unsigned YEAR_BASE = 1970;
  localparam int unsigned YEAR_MIN  = 2020;
  localparam int unsigned YEAR_MAX  = 2069;
  localparam logic [6:0] YOFF_MIN = 7'(YEAR_MIN - YEAR_BASE);
  localparam logic [6:0] YOFF_MAX = 7'(YEAR_MAX - YEAR_BASE);
  localparam logic [7:0] CENT_OFF = 8'(2000 - YEAR_BASE);
  localparam logic [7:0] MAX_HR   = 8'd23;
  localparam logic [7:0] MAX_MS   = 8'd59;
  localparam logic [7:0] MAX_DAY  = 8'd31;
  localparam logic [7:0] MAX_MON  = 8'd12;

  localparam logic [31:0] EPOCH_MIN = 32'd1577836800;  // 2020-01-01
  localparam logic [31:0] EPOCH_END = 32'd3155760000;  // 2070-01-01

  // Days since 1970 of the March-based year 2000, minus one for day-of-month.
  localparam logic [15:0] DAYS_BIAS = 16'd11016;

  // Reciprocals: floor(x/d) = (x*M) >> k, exact over each operand's range
  localparam logic [24:0] RECIP_DAY = 25'd25451659;   // /675 after >>7 (86400)
  localparam logic [15:0] RECIP_CYC = 16'd45934;      // /1461, k=26
  localparam logic [15:0] RECIP_WK  = 16'd37450;      // /7, k=18
  localparam logic [13:0] RECIP_HR  = 14'd9321;       // /225 after >>4 (3600)
  localparam logic [10:0] RECIP_MIN = 11'd1093;       // /15 after >>2 (60)
  localparam logic [7:0]  RECIP_TEN = 8'd205;         // /10, k=11

  // 2020-01-01 was a Wednesday
  localparam logic [14:0] WK_BIAS = 15'd3;

  // Start of years 1..3 within a leap-first four-year cycle
  localparam logic [10:0] YR1_START = 11'd366;
  localparam logic [10:0] YR2_START = 11'd731;
  localparam logic [10:0] YR3_START = 11'd1096;

  typedef struct packed {
    op_t         op;
    logic        ok;
    // decode side
    logic [6:0]  a;
    logic [8:0]  cum;
    logic [4:0]  dday;
    logic [4:0]  dhr;
    logic [5:0]  dmin;
    logic [5:0]  dsec;
    logic [15:0] days;
    logic [16:0] tod;
    logic [31:0] epoch;
    // encode side
    logic [30:0] ep;
    logic [14:0] dd;
    logic [16:0] rem;
    logic [3:0]  cyc;
    logic [2:0]  vlo;
    logic [2:0]  qlo;
    logic [10:0] r;
    logic [2:0]  wd;
    logic [4:0]  hr;
    logic [8:0]  doy;
    logic        leap;
    logic [6:0]  yoff;
    logic [11:0] rem2;
    logic [3:0]  mon;
    logic [4:0]  day;
    logic [5:0]  min;
  } stage_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] epoch;
    logic [6:0]  sec;
    logic [6:0]  min;
    logic [5:0]  hr;
    logic [5:0]  day;
    logic [2:0]  wd;
    logic [4:0]  mon;
    logic [7:0]  yr;
  } out_t;

  function automatic logic [7:0] bcd_dec(input logic [7:0] v);
    logic [7:0] t;
    logic [7:0] u;
    t = {4'b0, v[7:4] & MASK_NIB};
    u = {4'b0, v[3:0] & MASK_NIB};
    return (t << 3) + (t << 1) + u;
  endfunction

  function automatic logic [7:0] bcd_enc(input logic [6:0] v);
    logic [14:0] p;
    logic [3:0]  t;
    logic [3:0]  u;
    p = {8'b0, v} * {7'b0, RECIP_TEN};
    t = p[14:11];
    u = v[3:0] - (t * 4'd10);
    return {t, u};
  endfunction

  // Days before month m, year starting in March
  function automatic logic [8:0] cum_march(input logic [3:0] m);
    logic [8:0] c;
    unique case (m)
      4'd1:    c = 9'd306;
      4'd2:    c = 9'd337;
      4'd3:    c = 9'd0;
      4'd4:    c = 9'd31;
      4'd5:    c = 9'd61;
      4'd6:    c = 9'd92;
      4'd7:    c = 9'd122;
      4'd8:    c = 9'd153;
      4'd9:    c = 9'd184;
      4'd10:   c = 9'd214;
      4'd11:   c = 9'd245;
      4'd12:   c = 9'd275;
      default: c = 9'd0;
    endcase
    return c;
  endfunction

  // Day of year on which month index k (0 = January) starts
  function automatic logic [8:0] month_start(input logic [3:0] k, input logic leap);
    logic [8:0] c;
    unique case (k)
      4'd0:    c = 9'd0;
      4'd1:    c = 9'd31;
      4'd2:    c = 9'd59;
      4'd3:    c = 9'd90;
      4'd4:    c = 9'd120;
      4'd5:    c = 9'd151;
      4'd6:    c = 9'd181;
      4'd7:    c = 9'd212;
      4'd8:    c = 9'd243;
      4'd9:    c = 9'd273;
      4'd10:   c = 9'd304;
      4'd11:   c = 9'd334;
      default: c = 9'd0;
    endcase
    return (k >= 4'd2) ? c + {8'b0, leap} : c;
  endfunction

endpackage

### rtl/core/rtc_bcd_epoch_converter.sv
// BCD RTC register <-> Unix epoch converter; uses rtcbe_pkg.
// Pipeline: six stages plus an output register from input request to result.
// Throughput: one request per cycle while the output is not stalled; each stage
// advances when the next one is empty or moving, so bubbles close up behind a stalled output.
// Reset: synchronous active-low rst_n clears every stage valid and out_valid;
// data registers are not reset.
module rtc_bcd_epoch_converter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [7:0]  in_seconds_reg,
  input  logic [7:0]  in_minutes_reg,
  input  logic [7:0]  in_hours_reg,
  input  logic [7:0]  in_days_reg,
  input  logic [7:0]  in_months_reg,
  input  logic [7:0]  in_years_reg,
  input  logic [31:0] in_epoch_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_ok,
  output logic [31:0] out_epoch_out,
  output logic [6:0]  out_seconds_bcd,
  output logic [6:0]  out_minutes_bcd,
  output logic [5:0]  out_hours_bcd,
  output logic [5:0]  out_day_bcd,
  output logic [2:0]  out_weekday_bcd,
  output logic [4:0]  out_month_bcd,
  output logic [7:0]  out_year_bcd
);
  import rtcbe_pkg::*;

  // Stage map
  //   S1  decode: mask + BCD decode, range check, March-year offset, month table
  //       encode: range check, offset epoch from 2020-01-01
  //   S2  decode: day count and time of day;  encode: days = ep / 86400
  //   S3  decode: epoch = days*86400 + tod;    encode: seconds of day, 4-year
  //       cycle, weekday quotient
  //   S4  decode: floor check;                 encode: day in cycle, weekday, hours
  //   S5  encode: year in cycle, day of year, seconds within the hour
  //   S6  encode: month / day search, minutes
  //   out seconds, BCD packing, zeroing by opcode and status

  stage_t           stg_r   [1:NUM_STG];
  stage_t           stg_nxt [1:NUM_STG];
  logic [NUM_STG:1] vld_r;
  logic [NUM_STG:1] vld_nxt;
  out_t             out_r;
  out_t             out_nxt;
  logic             out_vld_r;
  logic             out_vld_nxt;

  // adv[k]: stage k loads this cycle; adv[NUM_STG+1] is the output register
  logic [NUM_STG+1:1] adv;

  always_comb begin
    adv[NUM_STG+1] = !out_vld_r || out_ready;
    for (int k = NUM_STG; k >= 1; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  assign in_ready = adv[1];

  always_comb begin
    vld_nxt = vld_r;
    out_vld_nxt = out_vld_r;
    if (adv[1]) vld_nxt[1] = in_valid;
    for (int k = 2; k <= NUM_STG; k++) begin
      if (adv[k]) vld_nxt[k] = vld_r[k-1];
    end
    if (adv[NUM_STG+1]) out_vld_nxt = vld_r[NUM_STG];
  end

  // ---------------- datapath ----------------
  always_comb begin
    logic [7:0]  sec8, min8, hr8, day8, mon8, yr8;
    logic        dec_ok, enc_ok, jf;
    logic [48:0] p_day;
    logic [30:0] p_cyc;
    logic [30:0] p_wk;
    logic [14:0] wk_v;
    logic [26:0] p_hr;
    logic [20:0] p_min;
    logic [1:0]  yi;
    logic [8:0]  st [12];
    logic [11:0] ge;
    logic [11:0] sel;
    logic [3:0]  mon;
    logic [8:0]  mst;

    // S1
    sec8 = bcd_dec(in_seconds_reg & MASK_MS);
    min8 = bcd_dec(in_minutes_reg & MASK_MS);
    hr8  = bcd_dec(in_hours_reg & MASK_HD);
    day8 = bcd_dec(in_days_reg & MASK_HD);
    mon8 = bcd_dec(in_months_reg & MASK_MON);
    yr8  = bcd_dec(in_years_reg);
    dec_ok = (yr8 >= {1'b0, YOFF_MIN}) && (yr8 <= {1'b0, YOFF_MAX}) &&
             (mon8 >= 8'd1) && (mon8 <= MAX_MON) &&
             (day8 >= 8'd1) && (day8 <= MAX_DAY) &&
             (hr8 <= MAX_HR) && (min8 <= MAX_MS) && (sec8 <= MAX_MS);
    enc_ok = (in_epoch_in >= EPOCH_MIN) && (in_epoch_in < EPOCH_END);
    jf = (mon8 <= 8'd2);  // Jan/Feb belong to the previous March-based year

    stg_nxt[1]      = '0;
    stg_nxt[1].op   = op_t'(in_opcode);
    stg_nxt[1].ok   = (in_opcode == OP_ENCODE) ? enc_ok : dec_ok;
    stg_nxt[1].a    = 7'(yr8 - CENT_OFF - {7'b0, jf});
    stg_nxt[1].cum  = cum_march(mon8[3:0]);
    stg_nxt[1].dday = day8[4:0];
    stg_nxt[1].dhr  = hr8[4:0];
    stg_nxt[1].dmin = min8[5:0];
    stg_nxt[1].dsec = sec8[5:0];
    stg_nxt[1].ep   = 31'(in_epoch_in - EPOCH_MIN);

    // S2
    stg_nxt[2] = stg_r[1];
    stg_nxt[2].days = DAYS_BIAS + ({9'b0, stg_r[1].a} * 16'd365) +
                      {11'b0, stg_r[1].a[6:2]} + {7'b0, stg_r[1].cum} +
                      {11'b0, stg_r[1].dday};
    stg_nxt[2].tod  = ({12'b0, stg_r[1].dhr} * 17'd3600) +
                      ({11'b0, stg_r[1].dmin} * 17'd60) + {11'b0, stg_r[1].dsec};
    p_day = {25'b0, stg_r[1].ep[30:7]} * {24'b0, RECIP_DAY};
    stg_nxt[2].dd = p_day[48:34];

    // S3
    stg_nxt[3] = stg_r[2];
    stg_nxt[3].epoch = ({16'b0, stg_r[2].days} * 32'd86400) + {15'b0, stg_r[2].tod};
    stg_nxt[3].rem   = stg_r[2].ep[16:0] - ({2'b0, stg_r[2].dd} * 17'd86400);
    p_cyc = {16'b0, stg_r[2].dd} * {15'b0, RECIP_CYC};
    stg_nxt[3].cyc = p_cyc[29:26];
    wk_v = stg_r[2].dd + WK_BIAS;
    p_wk = {16'b0, wk_v} * {15'b0, RECIP_WK};
    stg_nxt[3].vlo = wk_v[2:0];
    stg_nxt[3].qlo = p_wk[20:18];

    // S4
    stg_nxt[4] = stg_r[3];
    if (stg_r[3].op == OP_DECODE && stg_r[3].epoch < EPOCH_MIN) stg_nxt[4].ok = 1'b0;
    stg_nxt[4].r  = stg_r[3].dd[10:0] - ({7'b0, stg_r[3].cyc} * 11'd1461);
    stg_nxt[4].wd = stg_r[3].vlo - (stg_r[3].qlo * 3'd7);
    p_hr = {14'b0, stg_r[3].rem[16:4]} * {13'b0, RECIP_HR};
    stg_nxt[4].hr = p_hr[25:21];

    // S5
    stg_nxt[5] = stg_r[4];
    if (stg_r[4].r < YR1_START) begin
      yi = 2'd0;
      stg_nxt[5].doy = stg_r[4].r[8:0];
    end else if (stg_r[4].r < YR2_START) begin
      yi = 2'd1;
      stg_nxt[5].doy = 9'(stg_r[4].r - YR1_START);
    end else if (stg_r[4].r < YR3_START) begin
      yi = 2'd2;
      stg_nxt[5].doy = 9'(stg_r[4].r - YR2_START);
    end else begin
      yi = 2'd3;
      stg_nxt[5].doy = 9'(stg_r[4].r - YR3_START);
    end
    stg_nxt[5].leap = (yi == 2'd0);
    stg_nxt[5].yoff = YOFF_MIN + {1'b0, stg_r[4].cyc, 2'b0} + {5'b0, yi};
    stg_nxt[5].rem2 = stg_r[4].rem[11:0] - ({7'b0, stg_r[4].hr} * 12'd3600);

    // S6: thermometer compare against month starts, then one-hot select
    stg_nxt[6] = stg_r[5];
    for (int k = 0; k < 12; k++) begin
      st[k] = month_start(4'(k), stg_r[5].leap);
      ge[k] = (stg_r[5].doy >= st[k]);
    end
    mon = '0;
    mst = '0;
    for (int k = 0; k < 12; k++) begin
      sel[k] = (k == 11) ? ge[k] : (ge[k] && !ge[(k == 11) ? 11 : k + 1]);
      mon = mon | ({4{sel[k]}} & 4'(k + 1));
      mst = mst | ({9{sel[k]}} & st[k]);
    end
    stg_nxt[6].mon = mon;
    stg_nxt[6].day = 5'(stg_r[5].doy - mst + 9'd1);
    p_min = {11'b0, stg_r[5].rem2[11:2]} * {10'b0, RECIP_MIN};
    stg_nxt[6].min = p_min[19:14];
  end

  // Output formatting
  always_comb begin
    logic [5:0] sec6;
    logic [7:0] b_sec, b_min, b_hr, b_day, b_mon, b_yr;
    stage_t     s;
    s = stg_r[NUM_STG];
    sec6  = s.rem2[5:0] - (s.min * 6'd60);
    b_sec = bcd_enc({1'b0, sec6});
    b_min = bcd_enc({1'b0, s.min});
    b_hr  = bcd_enc({2'b0, s.hr});
    b_day = bcd_enc({2'b0, s.day});
    b_mon = bcd_enc({3'b0, s.mon});
    b_yr  = bcd_enc(s.yoff);
    out_nxt = '0;
    if (s.ok) begin
      out_nxt.ok = 1'b1;
      if (s.op == OP_ENCODE) begin
        out_nxt.sec = b_sec[6:0];
        out_nxt.min = b_min[6:0];
        out_nxt.hr  = b_hr[5:0];
        out_nxt.day = b_day[5:0];
        out_nxt.wd  = s.wd;
        out_nxt.mon = b_mon[4:0];
        out_nxt.yr  = b_yr;
      end else begin
        out_nxt.epoch = s.epoch;
      end
    end
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      vld_r     <= vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 1; k <= NUM_STG; k++) begin
      if (adv[k]) stg_r[k] <= stg_nxt[k];
    end
    if (adv[NUM_STG+1]) out_r <= out_nxt;
  end

  assign out_valid       = out_vld_r;
  assign out_ok          = out_r.ok;
  assign out_epoch_out   = out_r.epoch;
  assign out_seconds_bcd = out_r.sec;
  assign out_minutes_bcd = out_r.min;
  assign out_hours_bcd   = out_r.hr;
  assign out_day_bcd     = out_r.day;
  assign out_weekday_bcd = out_r.wd;
  assign out_month_bcd   = out_r.mon;
  assign out_year_bcd    = out_r.yr;

endmodule

### rtl/core/rtcbe_checker.sv
// Port-level checker for rtc_bcd_epoch_converter, bound into every instance of it.
// Depends on rtcbe_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rtcbe_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_opcode,
  input logic [7:0]  in_seconds_reg,
  input logic [7:0]  in_minutes_reg,
  input logic [7:0]  in_hours_reg,
  input logic [7:0]  in_days_reg,
  input logic [7:0]  in_months_reg,
  input logic [7:0]  in_years_reg,
  input logic [31:0] in_epoch_in,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_ok,
  input logic [31:0] out_epoch_out,
  input logic [6:0]  out_seconds_bcd,
  input logic [6:0]  out_minutes_bcd,
  input logic [5:0]  out_hours_bcd,
  input logic [5:0]  out_day_bcd,
  input logic [2:0]  out_weekday_bcd,
  input logic [4:0]  out_month_bcd,
  input logic [7:0]  out_year_bcd
);
  import rtcbe_pkg::*;

  // failed request: everything zero
  `CHK_IMP(a_fail_zero, out_valid && !out_ok, out_epoch_out == '0 && out_seconds_bcd == '0 && out_minutes_bcd == '0 && out_hours_bcd == '0 && out_day_bcd == '0 && out_weekday_bcd == '0 && out_month_bcd == '0 && out_year_bcd == '0)

  // decode result: epoch at or above EPOCH_MIN, BCD seconds, day, month and year clear
  `CHK_IMP(a_dec_clean, out_valid && out_ok && out_epoch_out != '0, out_epoch_out >= EPOCH_MIN && out_seconds_bcd == '0 && out_day_bcd == '0 && out_month_bcd == '0 && out_year_bcd == '0)

  // encode result: calendar fields plausible
  `CHK_IMP(a_enc_fields, out_valid && out_ok && out_epoch_out == '0, out_month_bcd != '0 && out_day_bcd != '0 && out_weekday_bcd <= 3'd6 && out_year_bcd >= 8'h50)

  // stalled result holds: out_valid, epoch, ok and year stay stable
  `CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_epoch_out) && $stable(out_ok) && $stable(out_year_bcd))

endmodule

bind rtc_bcd_epoch_converter rtcbe_checker u_rtcbe_checker (.*);
